@@ src/pal_pkg.sv @@
package pal_pkg;

   // Action codes of the request word
   localparam logic [2:0] ACT_INSERT = 3'd0;
   localparam logic [2:0] ACT_DELETE = 3'd1;
   localparam logic [2:0] ACT_READ   = 3'd2;
   localparam logic [2:0] ACT_LOCATE = 3'd3;
   localparam logic [2:0] ACT_CLEAR  = 3'd4;

   // Status codes of the response word
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BADPOS   = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_NOTFOUND = 2'd3;

   localparam int DATA_W = 32;
   localparam int POS_W  = 7;

   typedef enum logic [2:0] {
      PAL_IDLE,
      PAL_INS,
      PAL_INS_PUT,
      PAL_DEL_HEAD,
      PAL_DEL,
      PAL_RD,
      PAL_LOC,
      PAL_POST
   } pal_state_type;

   // Port enables from the sequencer to the entry store
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } pal_mem_ctl_type;

   // Finished result from the sequencer to the response register
   typedef struct packed {
      logic [1:0]        status;
      logic [DATA_W-1:0] data_out;
      logic [POS_W-1:0]  found_position;
      logic [POS_W-1:0]  list_length;
   } pal_result_type;

endpackage

@@ src/positional_array_list.sv @@
// Positional array list: dense list of 32-bit words in one synchronous store.
// Locate scans from the first entry until a hit or the end of the list; insert and delete
// move the entries behind the position one at a time through the store's read and write port.
// One request word in flight: no new request is taken until its result is in the response register.
// Reset clears the entry count; store contents are left as they are and need no sweep.
module positional_array_list import pal_pkg::*; #(
   parameter int CAPACITY = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [2:0]               req_action,
   input  logic [6:0]               req_position,
   input  logic signed [31:0]       req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [1:0]               rsp_status,
   output logic signed [31:0]       rsp_data_out,
   output logic [6:0]               rsp_found_position,
   output logic [6:0]               rsp_list_length
);

   localparam int AW = $clog2(CAPACITY);

   pal_mem_ctl_type   mem_ctl;
   logic [AW-1:0]     mem_rd_addr, mem_wr_addr;
   logic [DATA_W-1:0] mem_wr_data, mem_rd_data;
   logic              post_valid, post_ready;
   pal_result_type    post_result;

   logic              rsp_valid_ff, rsp_valid_in;
   pal_result_type    rsp_ff, rsp_in;

   pal_mem #(.CAPACITY(CAPACITY)) u_mem (
      .clock   (clock),
      .mem_ctl (mem_ctl),
      .rd_addr (mem_rd_addr),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data)
   );

   pal_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_action   (req_action),
      .req_position (req_position),
      .req_value    (req_value),
      .mem_ctl      (mem_ctl),
      .mem_rd_addr  (mem_rd_addr),
      .mem_wr_addr  (mem_wr_addr),
      .mem_wr_data  (mem_wr_data),
      .mem_rd_data  (mem_rd_data),
      .post_valid   (post_valid),
      .post_ready   (post_ready),
      .post_result  (post_result)
   );

   // Load a finished word when the slot is empty or draining
   assign post_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (post_valid && post_ready) begin
         rsp_valid_in = 1'b1;
         rsp_in       = post_result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_ff.status;
   assign rsp_data_out       = signed'(rsp_ff.data_out);
   assign rsp_found_position = rsp_ff.found_position;
   assign rsp_list_length    = rsp_ff.list_length;

endmodule

@@ src/pal_mem.sv @@
module pal_mem import pal_pkg::*; #(
   parameter int CAPACITY = 64
) (
   input  logic                          clock,
   input  pal_mem_ctl_type               mem_ctl,
   input  logic [$clog2(CAPACITY)-1:0]   rd_addr,
   input  logic [$clog2(CAPACITY)-1:0]   wr_addr,
   input  logic [DATA_W-1:0]             wr_data,
   output logic [DATA_W-1:0]             rd_data
);

   logic [DATA_W-1:0] store [CAPACITY];

   // Write one entry
   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         store[wr_addr] <= wr_data;
      end
   end

   // Read one entry, data registered for the next cycle
   always_ff @(posedge clock) begin
      if (mem_ctl.rd_en) begin
         rd_data <= store[rd_addr];
      end
   end

endmodule

@@ src/pal_ctrl.sv @@
module pal_ctrl import pal_pkg::*; #(
   parameter int CAPACITY = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [2:0]                    req_action,
   input  logic [POS_W-1:0]              req_position,
   input  logic [DATA_W-1:0]             req_value,
   output pal_mem_ctl_type               mem_ctl,
   output logic [$clog2(CAPACITY)-1:0]   mem_rd_addr,
   output logic [$clog2(CAPACITY)-1:0]   mem_wr_addr,
   output logic [DATA_W-1:0]             mem_wr_data,
   input  logic [DATA_W-1:0]             mem_rd_data,
   output logic                          post_valid,
   input  logic                          post_ready,
   output pal_result_type                post_result
);

   localparam int AW   = $clog2(CAPACITY);
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

   pal_state_type     state_ff, state_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [AW-1:0]     idx_ff, idx_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [DATA_W-1:0] val_ff, val_in;
   logic [1:0]        status_ff, status_in;
   logic [DATA_W-1:0] data_ff, data_in;
   logic [POS_W-1:0]  found_ff, found_in;

   logic [CMPW-1:0] pos_w, cnt_w, idx_w, posr_w;
   logic            req_fire;
   logic            ins_bad, rd_bad, is_full, ins_append;
   logic            ins_last, del_more, loc_hit, loc_last;

   // Compare at a common width
   assign pos_w  = CMPW'(req_position);
   assign cnt_w  = CMPW'(cnt_ff);
   assign idx_w  = CMPW'(idx_ff);
   assign posr_w = CMPW'(pos_ff);

   assign req_fire   = req_valid && req_ready;
   assign ins_bad    = (req_position == '0) || (pos_w > cnt_w + CMPW'(1));
   assign rd_bad     = (req_position == '0) || (pos_w > cnt_w);
   assign is_full    = (cnt_w == CMPW'(CAPACITY));
   assign ins_append = (pos_w == cnt_w + CMPW'(1));
   assign ins_last   = (idx_w + CMPW'(1) == posr_w);
   assign del_more   = (idx_w + CMPW'(1) < cnt_w);
   assign loc_hit    = (mem_rd_data == val_ff);
   assign loc_last   = (idx_w + CMPW'(1) == cnt_w);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         PAL_IDLE: begin
            if (req_fire) begin
               state_in = PAL_POST;
               priority case (req_action)
                  ACT_INSERT: if (!ins_bad && !is_full && !ins_append) state_in = PAL_INS;
                  ACT_DELETE: if (!rd_bad) state_in = PAL_DEL_HEAD;
                  ACT_READ:   if (!rd_bad) state_in = PAL_RD;
                  ACT_LOCATE: if (cnt_ff != '0) state_in = PAL_LOC;
                  default:    state_in = PAL_POST;
               endcase
            end
         end
         PAL_INS:      if (ins_last) state_in = PAL_INS_PUT;
         PAL_INS_PUT:  state_in = PAL_POST;
         PAL_DEL_HEAD: state_in = del_more ? PAL_DEL : PAL_POST;
         PAL_DEL:      if (!del_more) state_in = PAL_POST;
         PAL_RD:       state_in = PAL_POST;
         PAL_LOC:      if (loc_hit || loc_last) state_in = PAL_POST;
         PAL_POST:     if (post_ready) state_in = PAL_IDLE;
         default:      state_in = PAL_IDLE;
      endcase
   end

   // Store ports and handshake outputs
   always_comb begin
      mem_ctl     = '0;
      mem_rd_addr = '0;
      mem_wr_addr = '0;
      mem_wr_data = mem_rd_data;
      req_ready   = (state_ff == PAL_IDLE);
      post_valid  = (state_ff == PAL_POST);
      unique case (state_ff)
         PAL_IDLE: begin
            if (req_fire) begin
               priority case (req_action)
                  ACT_INSERT: begin
                     if (!ins_bad && !is_full) begin
                        if (ins_append) begin
                           mem_ctl.wr_en = 1'b1;
                           mem_wr_addr   = AW'(req_position - 7'd1);
                           mem_wr_data   = req_value;
                        end else begin
                           mem_ctl.rd_en = 1'b1;
                           mem_rd_addr   = AW'(cnt_ff - 1'b1);
                        end
                     end
                  end
                  ACT_DELETE, ACT_READ: begin
                     if (!rd_bad) begin
                        mem_ctl.rd_en = 1'b1;
                        mem_rd_addr   = AW'(req_position - 7'd1);
                     end
                  end
                  ACT_LOCATE: begin
                     mem_ctl.rd_en = (cnt_ff != '0);
                  end
                  default: mem_ctl = '0;
               endcase
            end
         end
         // Move the entry just read up by one, fetch the next lower one
         PAL_INS: begin
            mem_ctl.wr_en = 1'b1;
            mem_wr_addr   = AW'(idx_ff + 1'b1);
            if (!ins_last) begin
               mem_ctl.rd_en = 1'b1;
               mem_rd_addr   = AW'(idx_ff - 1'b1);
            end
         end
         PAL_INS_PUT: begin
            mem_ctl.wr_en = 1'b1;
            mem_wr_addr   = AW'(pos_ff - 7'd1);
            mem_wr_data   = val_ff;
         end
         PAL_DEL_HEAD: begin
            if (del_more) begin
               mem_ctl.rd_en = 1'b1;
               mem_rd_addr   = AW'(idx_ff + 1'b1);
            end
         end
         // Move the entry just read down by one, fetch the next higher one
         PAL_DEL: begin
            mem_ctl.wr_en = 1'b1;
            mem_wr_addr   = AW'(idx_ff - 1'b1);
            if (del_more) begin
               mem_ctl.rd_en = 1'b1;
               mem_rd_addr   = AW'(idx_ff + 1'b1);
            end
         end
         PAL_LOC: begin
            if (!loc_hit && !loc_last) begin
               mem_ctl.rd_en = 1'b1;
               mem_rd_addr   = AW'(idx_ff + 1'b1);
            end
         end
         default: mem_ctl = '0;
      endcase
   end

   // Datapath registers
   always_comb begin
      cnt_in    = cnt_ff;
      idx_in    = idx_ff;
      pos_in    = pos_ff;
      val_in    = val_ff;
      status_in = status_ff;
      data_in   = data_ff;
      found_in  = found_ff;
      unique case (state_ff)
         PAL_IDLE: begin
            if (req_fire) begin
               pos_in    = req_position;
               val_in    = req_value;
               status_in = ST_OK;
               data_in   = '0;
               found_in  = '0;
               priority case (req_action)
                  ACT_INSERT: begin
                     if (ins_bad) begin
                        status_in = ST_BADPOS;
                     end else if (is_full) begin
                        status_in = ST_FULL;
                     end else if (ins_append) begin
                        cnt_in = CW'(cnt_ff + 1'b1);
                     end else begin
                        idx_in = AW'(cnt_ff - 1'b1);
                     end
                  end
                  ACT_DELETE, ACT_READ: begin
                     if (rd_bad) status_in = ST_BADPOS;
                     else idx_in = AW'(req_position - 7'd1);
                  end
                  ACT_LOCATE: begin
                     idx_in = '0;
                     if (cnt_ff == '0) status_in = ST_NOTFOUND;
                  end
                  ACT_CLEAR: cnt_in = '0;
                  default:   status_in = ST_OK;
               endcase
            end
         end
         PAL_INS: begin
            if (!ins_last) idx_in = AW'(idx_ff - 1'b1);
         end
         PAL_INS_PUT: cnt_in = CW'(cnt_ff + 1'b1);
         PAL_DEL_HEAD: begin
            data_in = mem_rd_data;
            if (del_more) idx_in = AW'(idx_ff + 1'b1);
            else cnt_in = CW'(cnt_ff - 1'b1);
         end
         PAL_DEL: begin
            if (del_more) idx_in = AW'(idx_ff + 1'b1);
            else cnt_in = CW'(cnt_ff - 1'b1);
         end
         PAL_RD: data_in = mem_rd_data;
         PAL_LOC: begin
            if (loc_hit) found_in = POS_W'(idx_w + CMPW'(1));
            else if (loc_last) status_in = ST_NOTFOUND;
            else idx_in = AW'(idx_ff + 1'b1);
         end
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PAL_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      pos_ff    <= pos_in;
      val_ff    <= val_in;
      status_ff <= status_in;
      data_ff   <= data_in;
      found_ff  <= found_in;
   end

   assign post_result.status         = status_ff;
   assign post_result.data_out       = data_ff;
   assign post_result.found_position = found_ff;
   assign post_result.list_length    = POS_W'(cnt_ff);

   // Checks on the sequencer
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      CMPW'(cnt_ff) <= CMPW'(CAPACITY))
      else $error("entry count above capacity");

   a_port_clash: assert property (@(posedge clock) disable iff (reset)
      mem_ctl.rd_en && mem_ctl.wr_en |-> mem_rd_addr != mem_wr_addr)
      else $error("read and write to the same entry in one cycle");

   a_clear: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_action == ACT_CLEAR |=> cnt_ff == '0)
      else $error("clear left entries behind");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      post_valid |-> !req_ready)
      else $error("request taken while a result is pending");

endmodule

@@ tb/pal_tb_pkg.sv @@
`timescale 1ns / 1ps

package pal_tb_pkg;

   import pal_pkg::*;

   localparam int LIST_CAP    = 64;
   localparam int MAX_REPORTS = 200;

   // Shadow copy of the list plus the words still owed by the block
   class list_tracker;
      logic [31:0]    entries [LIST_CAP];
      int unsigned    count;
      pal_result_type owed_words [$];
      int unsigned    mismatches;
      int unsigned    reports;
      int unsigned    checked;
      int unsigned    action_seen [6];
      int unsigned    status_seen [4];

      function new();
         count      = 0;
         mismatches = 0;
         reports    = 0;
         checked    = 0;
         foreach (action_seen[i]) action_seen[i] = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      function int unsigned pending();
         return owed_words.size();
      endfunction

      // Apply one accepted request to the shadow list and queue its result
      function void note_request(logic [2:0] action, logic [6:0] pos, logic [31:0] value);
         pal_result_type res;
         int             k;
         res        = '0;
         res.status = ST_OK;
         action_seen[(action > ACT_CLEAR) ? 5 : action]++;
         case (action)
            ACT_INSERT: begin
               if (pos == 0 || pos > count + 1) begin
                  res.status = ST_BADPOS;
               end else if (count >= LIST_CAP) begin
                  res.status = ST_FULL;
               end else begin
                  // shift the tail up by one, then drop the word in
                  for (k = int'(count); k >= int'(pos); k--) entries[k] = entries[k-1];
                  entries[pos-1] = value;
                  count++;
               end
            end
            ACT_DELETE: begin
               if (pos == 0 || pos > count) begin
                  res.status = ST_BADPOS;
               end else begin
                  res.data_out = entries[pos-1];
                  for (k = int'(pos) - 1; k + 1 < int'(count); k++) entries[k] = entries[k+1];
                  count--;
               end
            end
            ACT_READ: begin
               if (pos == 0 || pos > count) res.status = ST_BADPOS;
               else res.data_out = entries[pos-1];
            end
            ACT_LOCATE: begin
               // first match wins
               for (k = 0; k < int'(count); k++) begin
                  if (entries[k] == value) begin
                     res.found_position = 7'(k + 1);
                     break;
                  end
               end
               if (res.found_position == 0) res.status = ST_NOTFOUND;
            end
            ACT_CLEAR: count = 0;
            default: ;
         endcase
         res.list_length = 7'(count);
         owed_words.push_back(res);
      endfunction

      function void report(string field, logic [31:0] exp_v, logic [31:0] got_v);
         reports++;
         if (reports <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %h, got %h", $time, field, exp_v, got_v);
      endfunction

      // Compare one accepted response word against the oldest owed word
      function void check_response(pal_result_type got);
         pal_result_type exp;
         bit             bad;
         status_seen[got.status]++;
         if (owed_words.size() == 0) begin
            mismatches++;
            $display("%0t: response word with nothing owed, status %0d data %h", $time,
                     got.status, got.data_out);
            return;
         end
         exp = owed_words.pop_front();
         bad = 0;
         checked++;
         if (got.status != exp.status) begin
            report("status", 32'(exp.status), 32'(got.status));
            bad = 1;
         end
         if (got.data_out != exp.data_out) begin
            report("data_out", exp.data_out, got.data_out);
            bad = 1;
         end
         if (got.found_position != exp.found_position) begin
            report("found_position", 32'(exp.found_position), 32'(got.found_position));
            bad = 1;
         end
         if (got.list_length != exp.list_length) begin
            report("list_length", 32'(exp.list_length), 32'(got.list_length));
            bad = 1;
         end
         if (bad) mismatches++;
      endfunction
   endclass

endpackage

@@ tb/tb_positional_array_list.sv @@
`timescale 1ns / 1ps

module tb_positional_array_list;

   import pal_pkg::*;
   import pal_tb_pkg::*;

   localparam int TOTAL_WORDS = 950;
   localparam int CYCLE_LIMIT = 600000;
   localparam int LONG_HOLD   = 300;
   localparam int TAIL_CYCLES = 100;

   // Kinds of random phase
   localparam int PH_GROW   = 0;
   localparam int PH_SHRINK = 1;
   localparam int PH_MIXED  = 2;
   localparam int PH_NOISE  = 3;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [2:0]        req_action;
   logic [6:0]        req_position;
   logic signed [31:0] req_value;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [1:0]        rsp_status;
   logic signed [31:0] rsp_data_out;
   logic [6:0]        rsp_found_position;
   logic [6:0]        rsp_list_length;

   list_tracker tracker;
   bit          idle_en;
   bit          long_hold;
   int unsigned words_sent;
   int unsigned cycle_count = 0;

   positional_array_list #(.CAPACITY(LIST_CAP)) DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_action         (req_action),
      .req_position       (req_position),
      .req_value          (req_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_data_out       (rsp_data_out),
      .rsp_found_position (rsp_found_position),
      .rsp_list_length    (rsp_list_length)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d words still owed", cycle_count,
                  tracker.pending());
         $display("Regression FAIL");
         $finish;
      end
   end

   // Offer one request word and hold it until the block takes it
   task automatic send_word(input logic [2:0] action, input logic [6:0] pos,
                            input logic [31:0] value);
      int unsigned gap;
      gap = idle_en ? $urandom_range(0, 16) : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    = 1'b1;
      req_action   = action;
      req_position = pos;
      req_value    = value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.note_request(action, pos, value);
      words_sent++;
   endtask

   // Stop offering and wait for every owed response word
   task automatic drain_responses();
      @(negedge clock);
      req_valid = 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   // Favor both ends of the legal range
   function automatic logic [6:0] pick_pos(int unsigned limit);
      case ($urandom_range(0, 7))
         0:       return 7'd1;
         1:       return 7'(limit);
         default: return 7'($urandom_range(1, limit));
      endcase
   endfunction

   // Extremes, a narrow band that makes duplicates, or anything
   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 7))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         4, 5:    return 32'($urandom_range(0, 7));
         default: return $urandom;
      endcase
   endfunction

   // Build one random request word for the given phase kind and send it
   task automatic send_random(input int kind);
      logic [2:0]  action;
      logic [6:0]  pos;
      logic [31:0] value;
      int unsigned roll;
      int unsigned n;
      n    = tracker.count;
      roll = $urandom_range(0, 99);
      if (kind == PH_NOISE || roll < 8) begin
         action = 3'($urandom_range(0, 7));
         pos    = 7'($urandom_range(0, 127));
         value  = $urandom;
      end else begin
         case (kind)
            PH_GROW:   action = (roll < 85) ? ACT_INSERT : (roll < 93) ? ACT_READ : ACT_LOCATE;
            PH_SHRINK: action = (roll < 80) ? ACT_DELETE : (roll < 90) ? ACT_READ : ACT_LOCATE;
            default: begin
               if (roll < 30)      action = ACT_INSERT;
               else if (roll < 55) action = ACT_DELETE;
               else if (roll < 75) action = ACT_READ;
               else if (roll < 97) action = ACT_LOCATE;
               else                action = ACT_CLEAR;
            end
         endcase
         if (action == ACT_INSERT) pos = pick_pos(n + 1);
         else if (n == 0)          pos = 7'd1;
         else                      pos = pick_pos(n);
         if (action == ACT_LOCATE && n != 0 && $urandom_range(0, 1) == 1)
            value = tracker.entries[$urandom_range(0, n - 1)];
         else
            value = pick_value();
      end
      send_word(action, pos, value);
   endtask

   // Response side: random stalls, one long hold on request
   initial begin : rsp_side
      int unsigned gap;
      pal_result_type got;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_ready = 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            long_hold = 1'b0;
         end
         gap = idle_en ? $urandom_range(0, 16) : 0;
         if (gap != 0) begin
            rsp_ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready = 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         got.status         = rsp_status;
         got.data_out       = rsp_data_out;
         got.found_position = rsp_found_position;
         got.list_length    = rsp_list_length;
         tracker.check_response(got);
      end
   end

   // Request side and run control
   initial begin : req_side
      int kind;
      int len;
      int phase_no;
      tracker      = new();
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_action   = ACT_INSERT;
      req_position = '0;
      req_value    = '0;
      idle_en      = 1'b1;
      long_hold    = 1'b0;
      words_sent   = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty list: every position is bad, locate misses
      send_word(ACT_READ,   7'd1,   32'h0);
      send_word(ACT_DELETE, 7'd1,   32'h0);
      send_word(ACT_LOCATE, 7'd0,   32'h0);
      send_word(ACT_INSERT, 7'd0,   32'h1234_5678);
      send_word(ACT_INSERT, 7'd2,   32'h1234_5678);
      // build a short list at front, end and middle
      send_word(ACT_INSERT, 7'd1,   32'h8000_0000);
      send_word(ACT_INSERT, 7'd1,   32'h7FFF_FFFF);
      send_word(ACT_INSERT, 7'd3,   32'hFFFF_FFFF);
      send_word(ACT_INSERT, 7'd2,   32'h0000_0000);
      send_word(ACT_READ,   7'd1,   32'h0);
      send_word(ACT_READ,   7'd4,   32'h0);
      send_word(ACT_READ,   7'd5,   32'h0);
      send_word(ACT_READ,   7'd0,   32'h0);
      send_word(ACT_LOCATE, 7'd0,   32'h8000_0000);
      send_word(ACT_LOCATE, 7'd127, 32'd12345);
      // deletes: out of range, middle, last, first
      send_word(ACT_DELETE, 7'd127, 32'h0);
      send_word(ACT_DELETE, 7'd0,   32'h0);
      send_word(ACT_DELETE, 7'd2,   32'h0);
      send_word(ACT_DELETE, 7'd3,   32'h0);
      send_word(ACT_DELETE, 7'd1,   32'h0);
      // unused actions leave the list alone
      send_word(3'd5,       7'd127, 32'hFFFF_FFFF);
      send_word(3'd6,       7'd1,   32'h0);
      send_word(3'd7,       7'd127, 32'hFFFF_FFFF);
      send_word(ACT_CLEAR,  7'd0,   32'h0);
      send_word(ACT_READ,   7'd1,   32'h0);

      // random phases; the first fills the list past full
      phase_no = 0;
      while (words_sent < TOTAL_WORDS) begin
         if (phase_no == 0) begin
            kind = PH_GROW;
            len  = 110;
         end else begin
            kind = $urandom_range(PH_GROW, PH_NOISE);
            len  = $urandom_range(20, 80);
         end
         idle_en = (phase_no == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
         if (phase_no == 3) long_hold = 1'b1;
         for (int i = 0; i < len; i++) send_random(kind);
         if (phase_no == 2 || $urandom_range(0, 3) == 0) drain_responses();
         phase_no++;
      end

      drain_responses();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d words (insert %0d, delete %0d, read %0d, locate %0d, clear %0d, unused %0d)",
               words_sent, tracker.action_seen[0], tracker.action_seen[1],
               tracker.action_seen[2], tracker.action_seen[3], tracker.action_seen[4],
               tracker.action_seen[5]);
      $display("Checked %0d responses (ok %0d, bad position %0d, full %0d, not found %0d), %0d bad",
               tracker.checked, tracker.status_seen[0], tracker.status_seen[1],
               tracker.status_seen[2], tracker.status_seen[3], tracker.mismatches);
      if (tracker.mismatches == 0 && tracker.pending() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

@@ positional_array_list.f @@
src/pal_pkg.sv
src/pal_mem.sv
src/pal_ctrl.sv
src/positional_array_list.sv
tb/pal_tb_pkg.sv
tb/tb_positional_array_list.sv
